/* rtl/bcd_time_set_editor_top_macros.svh */
// ----------------------------------------------------------------------------
// BCD time set editor assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef BCD_TIME_SET_EDITOR_TOP_MACROS_SVH
`define BCD_TIME_SET_EDITOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define BTSE_ASSERT(lbl, clock, rstn, prop, msg) \
    lbl: assert property (@(posedge clock) disable iff (!rstn) prop) else $error(msg);
`define BTSE_ASSERT_NEVER(lbl, clock, rstn, cond, msg) \
    lbl: assert property (@(posedge clock) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define BTSE_ASSERT(lbl, clock, rstn, prop, msg)
`define BTSE_ASSERT_NEVER(lbl, clock, rstn, cond, msg)
`endif

`endif

/* rtl/btse_pkg.sv */
// ----------------------------------------------------------------------------
// BCD time set editor package
// Opcode and key codes, cursor positions and BCD digit step functions.
// ----------------------------------------------------------------------------
`default_nettype none

package btse_pkg;

    typedef enum logic [1:0] {
        OP_ACTIVATE   = 2'd0,
        OP_KEY        = 2'd1,
        OP_DEACTIVATE = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        KEY_DONE  = 3'd0,
        KEY_LEFT  = 3'd1,
        KEY_RIGHT = 3'd2,
        KEY_DEC   = 3'd3,
        KEY_INC   = 3'd4
    } key_t;

    typedef logic [2:0] cursor_t;
    typedef logic [7:0] bcd_t;

    localparam cursor_t CUR_HOUR_TENS  = 3'd0;
    localparam cursor_t CUR_HOUR_UNITS = 3'd1;
    localparam cursor_t CUR_MIN_TENS   = 3'd2;
    localparam cursor_t CUR_MIN_UNITS  = 3'd3;
    localparam cursor_t CUR_LAST       = 3'd4;

    function automatic bcd_t hour_up(input bcd_t h_in, input logic tens);
        bcd_t h;
        h = h_in;
        if (tens)
        begin
            h = h + 8'h10;
            if (h[7:4] == 4'h3)
                h = {4'h0, h[3:0]};
            else if (h[7:4] == 4'h2 && h[3:0] > 4'h3)
                h = {h[7:4], 4'h3};
        end
        else
        begin
            h = h + 8'h01;
            if (h[7:4] == 4'h2)
            begin
                if (h[3:0] > 4'h3)
                    h = {h[7:4], 4'h0};
            end
            else if (h[3:0] > 4'h9)
                h = {h[7:4], 4'h0};
        end
        return h;
    endfunction

    function automatic bcd_t hour_down(input bcd_t h_in, input logic tens);
        bcd_t h;
        h = h_in;
        if (tens)
        begin
            if (h[7:4] != 4'h0)
                h = h - 8'h10;
            else if (h[3:0] > 4'h3)
                h = 8'h23;
            else
                h = {4'h2, h[3:0]};
        end
        else
        begin
            if (h[3:0] != 4'h0)
                h = h - 8'h01;
            else if (h[7:4] == 4'h2)
                h = {h[7:4], 4'h3};
            else
                h = {h[7:4], 4'h9};
        end
        return h;
    endfunction

    function automatic bcd_t minute_up(input bcd_t m_in, input logic tens);
        bcd_t m;
        m = m_in;
        if (tens)
        begin
            m = m + 8'h10;
            if (m[7:4] == 4'h6)
                m = {4'h0, m[3:0]};
        end
        else
        begin
            m = m + 8'h01;
            if (m[3:0] > 4'h9)
                m = {m[7:4], 4'h0};
        end
        return m;
    endfunction

    function automatic bcd_t minute_down(input bcd_t m_in, input logic tens);
        bcd_t m;
        m = m_in;
        if (tens)
        begin
            if (m[7:4] != 4'h0)
                m = m - 8'h10;
            else
                m = {4'h5, m[3:0]};
        end
        else
        begin
            if (m[3:0] != 4'h0)
                m = m - 8'h01;
            else
                m = {m[7:4], 4'h9};
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* rtl/bcd_time_set_editor_top.sv */
// ----------------------------------------------------------------------------
// BCD time set editor
// Key-driven editor for a 24-hour BCD time with a five-position cursor.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one item per request: an opcode
// (activate with start time, key event, deactivate), a key code and the
// start hour and minute. Output channel (out_valid / out_stall) returns one
// item per input item: done flag, current hour, minute, cursor and active.
// An accepted item is held in an input register; when the output stage
// advances it is applied to the editor state and the result is loaded into
// the output register. Both stages advance together, so one item per cycle
// is accepted while out_stall stays low. The state update is combinational
// nibble compares and adds.
// While a result is offered and out_stall is high, the result and editor
// state hold, and in_stall rises once the input register is also occupied.
// Reset clears both stages, leaves the editor idle with cursor on the hour
// tens digit and time 00:00.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_time_set_editor_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] opcode,
    input  wire logic [2:0] key_code,
    input  wire logic [7:0] start_hour,
    input  wire logic [7:0] start_minute,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            done_res,
    output logic [7:0]      hour_out,
    output logic [7:0]      minute_out,
    output logic [2:0]      cursor_out,
    output logic            active_out
);
    import btse_pkg::*;

    `include "bcd_time_set_editor_top_macros.svh"

    logic    s1_valid_reg;
    opcode_t op_reg;
    logic [2:0] key_reg;
    bcd_t    sh_reg;
    bcd_t    sm_reg;

    logic    out_valid_reg;
    logic    done_reg;
    logic    active_reg;
    cursor_t cursor_reg;
    bcd_t    hour_reg;
    bcd_t    minute_reg;

    logic    done_next;
    logic    active_next;
    cursor_t cursor_next;
    bcd_t    hour_next;
    bcd_t    minute_next;

    logic    advance;
    logic    in_take;

    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        done_next   = 1'b0;
        active_next = active_reg;
        cursor_next = cursor_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        unique case (op_reg)
            OP_ACTIVATE:
            begin
                if (!active_reg)
                begin
                    hour_next   = sh_reg;
                    minute_next = sm_reg;
                    cursor_next = CUR_HOUR_TENS;
                    active_next = 1'b1;
                end
            end
            OP_KEY:
            begin
                if (active_reg)
                begin
                    unique case (key_reg)
                        KEY_DONE:
                        begin
                            done_next   = 1'b1;
                            active_next = 1'b0;
                        end
                        KEY_LEFT:
                            cursor_next = (cursor_reg == CUR_HOUR_TENS) ? CUR_LAST
                                                                        : cursor_reg - 3'd1;
                        KEY_RIGHT:
                            cursor_next = (cursor_reg >= CUR_LAST) ? CUR_HOUR_TENS
                                                                   : cursor_reg + 3'd1;
                        KEY_DEC, KEY_INC:
                        begin
                            case (cursor_reg)
                                CUR_HOUR_TENS:
                                    hour_next = (key_reg == KEY_INC) ? hour_up(hour_reg, 1'b1)
                                                                     : hour_down(hour_reg, 1'b1);
                                CUR_HOUR_UNITS:
                                    hour_next = (key_reg == KEY_INC) ? hour_up(hour_reg, 1'b0)
                                                                     : hour_down(hour_reg, 1'b0);
                                CUR_MIN_TENS:
                                    minute_next = (key_reg == KEY_INC)
                                                  ? minute_up(minute_reg, 1'b1)
                                                  : minute_down(minute_reg, 1'b1);
                                CUR_MIN_UNITS:
                                    minute_next = (key_reg == KEY_INC)
                                                  ? minute_up(minute_reg, 1'b0)
                                                  : minute_down(minute_reg, 1'b0);
                                default:
                                    ;
                            endcase
                        end
                        default:
                            ;
                    endcase
                end
            end
            OP_DEACTIVATE:
                active_next = 1'b0;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            active_reg    <= 1'b0;
            cursor_reg    <= CUR_HOUR_TENS;
            hour_reg      <= 8'h00;
            minute_reg    <= 8'h00;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
                if (s1_valid_reg)
                begin
                    done_reg   <= done_next;
                    active_reg <= active_next;
                    cursor_reg <= cursor_next;
                    hour_reg   <= hour_next;
                    minute_reg <= minute_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg  <= opcode_t'(opcode);
            key_reg <= key_code;
            sh_reg  <= start_hour;
            sm_reg  <= start_minute;
        end
    end

    assign out_valid  = out_valid_reg;
    assign done_res   = done_reg;
    assign hour_out   = hour_reg;
    assign minute_out = minute_reg;
    assign cursor_out = cursor_reg;
    assign active_out = active_reg;

    `BTSE_ASSERT_NEVER(a_cursor_range, clk, rst_n, cursor_reg > CUR_LAST,
                       "cursor beyond OK position")
    `BTSE_ASSERT(a_done_idle, clk, rst_n, out_valid_reg && done_reg |-> !active_reg,
                 "done reported while still active")
    `BTSE_ASSERT(a_activate, clk, rst_n,
                 s1_valid_reg && advance && op_reg == OP_ACTIVATE |=> active_reg,
                 "activate did not leave editor active")
    `BTSE_ASSERT(a_deactivate, clk, rst_n,
                 s1_valid_reg && advance && op_reg == OP_DEACTIVATE |=> !active_reg && !done_reg,
                 "deactivate left editor active or flagged done")

endmodule

`default_nettype wire
